// ===== hdl/acrle_pkg.sv =====
// Shared types, constants and helpers for the AC run-length encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package acrle_pkg;

    localparam int CoefW = 16;
    localparam int AmpW  = 15;
    localparam int RunW  = 4;
    localparam int SizeW = 4;
    localparam int PosW  = 12;

    localparam logic [RunW-1:0] RUN_CODE     = 4'd15;
    localparam logic [PosW-1:0] AC_PER_BLOCK_RESET = 12'd63;
    localparam logic [AmpW-1:0] AMP_MAX      = 15'h7FFF;

    typedef struct packed {
        logic [RunW-1:0]  zero_run;
        logic [SizeW-1:0] size_category;
        logic [AmpW-1:0]  amplitude;
        logic             end_of_block;
        logic             last_result;
    } sym_t;

    typedef struct packed {
        logic have_sym;
        logic end_block;
        sym_t sym;
    } enc_t;

    typedef struct packed {
        logic free;
        logic eob_pending;
    } buf_status_t;

    localparam sym_t EOB_SYM = '{zero_run: '0, size_category: '0, amplitude: '0,
                                 end_of_block: 1'b1, last_result: 1'b1};

    function automatic logic [SizeW-1:0] bit_len(input logic [AmpW-1:0] mag);
        logic [SizeW-1:0] n;
        n = '0;
        for (int i = 0; i < AmpW; i++) begin
            if (mag[i])
            begin
                n = SizeW'(i + 1);
            end
        end
        return n;
    endfunction

endpackage : acrle_pkg
`default_nettype wire

// ===== hdl/ac_run_length_encoder.sv =====
// Top level of the AC run-length encoder: input register, length register,
// encoder and output buffer. Depends on acrle_pkg, acrle_encoder, acrle_out_buf.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   coefficient
//   out      output     out_valid / out_stall zero_run, size_category, amplitude,
//                                             end_of_block, last_result
//   cfg      input      cfg_valid / cfg_ready cfg_data (ac_per_block)
//
// One coefficient per cycle unless in_stall is high; an item that yields a symbol
// and end-of-block emits the symbol, then end-of-block, from the single output register.
// An input transaction passes the input register, then the output register, before its first result.
// Reset clears run count, position and all valids; ac_per_block resets to 63.
// Output stall backs up into in_stall once the output slot and input register fill.
`default_nettype none
module ac_run_length_encoder
    import acrle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CoefW-1:0]  coefficient,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [RunW-1:0]        zero_run,
    output logic [SizeW-1:0]       size_category,
    output logic [AmpW-1:0]        amplitude,
    output logic                   end_of_block,
    output logic                   last_result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [PosW-1:0]   cfg_data
);

    logic             in_valid_reg;
    logic [CoefW-1:0] coef_reg;
    logic [PosW-1:0]  ac_per_block_reg;
    logic             advance;
    logic             in_take;
    enc_t             enc;
    buf_status_t      status;
    sym_t             out_sym;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && status.free;
    assign in_stall  = in_valid_reg && !status.free;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            ac_per_block_reg <= AC_PER_BLOCK_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                ac_per_block_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            coef_reg <= coefficient;
        end
    end

    acrle_encoder u_encoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .coef         (coef_reg),
        .ac_per_block (ac_per_block_reg),
        .enc          (enc)
    );

    acrle_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .enc       (enc),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_sym   (out_sym)
    );

    assign zero_run      = out_sym.zero_run;
    assign size_category = out_sym.size_category;
    assign amplitude     = out_sym.amplitude;
    assign end_of_block  = out_sym.end_of_block;
    assign last_result   = out_sym.last_result;

    a_pend_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        status.eob_pending |-> out_valid)
        else $error("pending end-of-block without a valid output");

    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status.eob_pending) |-> (!last_result && !end_of_block))
        else $error("symbol ahead of end-of-block marked last");

    a_eob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_block) |->
        (last_result && zero_run == '0 && size_category == '0 && amplitude == '0))
        else $error("malformed end-of-block symbol");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg)
        else $error("input register dropped a stalled item");

endmodule : ac_run_length_encoder
`default_nettype wire

// ===== hdl/acrle_encoder.sv =====
// Run/size/amplitude encoding of one registered coefficient plus run and
// position state. Depends on acrle_pkg.
`default_nettype none
module acrle_encoder
    import acrle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [CoefW-1:0]  coef,
    input  wire logic [PosW-1:0]   ac_per_block,
    output enc_t                   enc
);

    logic [RunW-1:0]  run_count_reg, run_count_next;
    logic [PosW-1:0]  position_reg, position_next;

    logic             negative;
    logic             is_zero;
    logic [CoefW-1:0] mag_full;
    logic [AmpW-1:0]  mag;
    logic [SizeW-1:0] size;
    logic [AmpW:0]    mask;
    logic [AmpW-1:0]  amp;
    logic [PosW:0]    pos_inc;
    logic             end_block;
    logic             run_full;

    always_comb
    begin
        negative  = coef[CoefW-1];
        is_zero   = (coef == '0);
        mag_full  = negative ? (CoefW'(0) - coef) : coef;
        // saturate the most negative code
        mag       = mag_full[CoefW-1] ? AMP_MAX : mag_full[AmpW-1:0];
        size      = bit_len(mag);
        mask      = ((AmpW+1)'(1) << size) - (AmpW+1)'(1);
        amp       = negative ? (~mag & mask[AmpW-1:0]) : mag;
        run_full  = (run_count_reg == RUN_CODE);
        pos_inc   = {1'b0, position_reg} + (PosW+1)'(1);
        end_block = (pos_inc >= {1'b0, ac_per_block});

        enc.end_block              = end_block;
        enc.have_sym               = !is_zero || run_full;
        enc.sym.zero_run           = is_zero ? RUN_CODE : run_count_reg;
        enc.sym.size_category      = is_zero ? '0 : size;
        enc.sym.amplitude          = is_zero ? '0 : amp;
        enc.sym.end_of_block       = 1'b0;
        enc.sym.last_result        = !end_block;

        run_count_next = run_count_reg;
        position_next  = position_reg;
        if (advance)
        begin
            if (end_block)
            begin
                run_count_next = '0;
                position_next  = '0;
            end
            else
            begin
                position_next  = pos_inc[PosW-1:0];
                run_count_next = (is_zero && !run_full) ? run_count_reg + RunW'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            position_reg  <= '0;
        end
        else
        begin
            run_count_reg <= run_count_next;
            position_reg  <= position_next;
        end
    end

endmodule : acrle_encoder
`default_nettype wire

// ===== hdl/acrle_out_buf.sv =====
// Output register with one pending end-of-block slot.
// Depends on acrle_pkg.
`default_nettype none
module acrle_out_buf
    import acrle_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire enc_t  enc,
    input  wire logic  out_stall,
    output buf_status_t status,
    output logic       out_valid,
    output sym_t       out_sym
);

    logic out_valid_reg, out_valid_next;
    logic eob_pend_reg, eob_pend_next;
    sym_t sym_reg, sym_next;
    logic take;

    always_comb
    begin
        take           = out_valid_reg && !out_stall;
        status.free    = !out_valid_reg || (take && !eob_pend_reg);
        status.eob_pending = eob_pend_reg;

        out_valid_next = out_valid_reg;
        eob_pend_next  = eob_pend_reg;
        sym_next       = sym_reg;
        if (load)
        begin
            if (enc.have_sym)
            begin
                out_valid_next = 1'b1;
                sym_next       = enc.sym;
                eob_pend_next  = enc.end_block;
            end
            else if (enc.end_block)
            begin
                out_valid_next = 1'b1;
                sym_next       = EOB_SYM;
                eob_pend_next  = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
                eob_pend_next  = 1'b0;
            end
        end
        else if (take)
        begin
            if (eob_pend_reg)
            begin
                sym_next      = EOB_SYM;
                eob_pend_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            eob_pend_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            eob_pend_reg  <= eob_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign out_valid = out_valid_reg;
    assign out_sym   = sym_reg;

endmodule : acrle_out_buf
`default_nettype wire

// ===== sim/ac_run_length_encoder_tb.sv =====
// Self-checking testbench for ac_run_length_encoder: streams AC coefficients,
// predicts the run / size / amplitude symbols and compares every transaction.
// Depends on acrle_pkg and the ac_run_length_encoder RTL.
`timescale 1ns / 1ps

module ac_run_length_encoder_tb;
    import acrle_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CoefW-1:0]  coefficient = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [RunW-1:0]   zero_run;
    logic [SizeW-1:0]  size_category;
    logic [AmpW-1:0]   amplitude;
    logic              end_of_block;
    logic              last_result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [PosW-1:0]   cfg_data = '0;

    logic [CoefW-1:0]  coef_pending_q[$];
    sym_t              sym_expect_q[$];

    // encoder state tracked by the monitor
    logic [RunW-1:0]   run_zeros = '0;
    logic [PosW-1:0]   blk_pos = '0;
    logic [PosW-1:0]   blk_len = AC_PER_BLOCK_RESET;

    logic              coef_taken = 1'b0;
    int                cycle_cnt = 0;
    int                coef_count = 0;
    int                sym_count = 0;
    int                blocks_done = 0;
    int                len_writes = 0;
    int                err_count = 0;
    logic              press_req = 1'b0;
    logic              hold_done = 1'b0;
    int                hold_left = 0;
    logic              quiet_window;

    logic [PosW-1:0]   phase_len[13] = '{12'd4095, 12'd1, 12'd63, 12'd16, 12'd2, 12'd17,
                                         12'd4095, 12'd5, 12'd64, 12'd33, 12'd0, 12'd8,
                                         12'd100};

    assign quiet_window = (cycle_cnt >= 1000) && (cycle_cnt < 1600);

    ac_run_length_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coefficient   (coefficient),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .zero_run      (zero_run),
        .size_category (size_category),
        .amplitude     (amplitude),
        .end_of_block  (end_of_block),
        .last_result   (last_result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic expect_symbol(input sym_t sym);
        sym_expect_q.insert(sym_expect_q.size(), sym);
    endtask

    task automatic queue_coef(input logic [CoefW-1:0] coef);
        coef_pending_q.insert(coef_pending_q.size(), coef);
    endtask

    task automatic encode_coefficient(input logic [CoefW-1:0] coef);
        int unsigned mag;
        int unsigned nbits;
        logic        sym_due;
        logic        block_done;
        sym_t        sym;
        sym = '0;
        sym_due = 1'b0;
        mag = coef[CoefW-1] ? 32'd65536 - coef : coef;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        if (coef == '0)
        begin
            if (run_zeros == 4'd15)
            begin
                sym.zero_run = RUN_CODE;
                sym_due = 1'b1;
                run_zeros = '0;
            end
            else
            begin
                run_zeros++;
            end
        end
        else
        begin
            nbits = 0;
            while ((mag >> nbits) != 0)
            begin
                nbits++;
            end
            sym.zero_run = run_zeros;
            sym.size_category = nbits[SizeW-1:0];
            sym.amplitude = coef[CoefW-1] ? AmpW'((1 << nbits) - 1 - mag) : AmpW'(mag);
            sym_due = 1'b1;
            run_zeros = '0;
        end
        block_done = (int'(blk_pos) + 1) >= int'(blk_len);
        if (sym_due)
        begin
            sym.last_result = !block_done;
            expect_symbol(sym);
        end
        if (block_done)
        begin
            expect_symbol(EOB_SYM);
            run_zeros = '0;
            blk_pos = '0;
        end
        else
        begin
            blk_pos = blk_pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [AmpW-1:0] want,
                               input logic [AmpW-1:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // monitor: sample at the rising edge
    always @(posedge clk)
    begin
        sym_t want;
        if (!rst_n)
        begin
            run_zeros = '0;
            blk_pos = '0;
            blk_len = AC_PER_BLOCK_RESET;
            coef_taken <= 1'b0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            coef_taken <= in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
            begin
                blk_len = cfg_data;
                len_writes++;
            end
            if (out_valid && !out_stall)
            begin
                if (sym_expect_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected symbol, expected none, actual %0h/%0h/%0h/%0b/%0b",
                             $time, zero_run, size_category, amplitude, end_of_block,
                             last_result);
                end
                else
                begin
                    want = sym_expect_q.pop_front();
                    check_field("zero_run", AmpW'(want.zero_run), AmpW'(zero_run));
                    check_field("size_category", AmpW'(want.size_category),
                                AmpW'(size_category));
                    check_field("amplitude", want.amplitude, amplitude);
                    check_field("end_of_block", AmpW'(want.end_of_block), AmpW'(end_of_block));
                    check_field("last_result", AmpW'(want.last_result), AmpW'(last_result));
                end
                sym_count++;
                if (end_of_block === 1'b1)
                begin
                    blocks_done++;
                end
            end
            if (in_valid && !in_stall)
            begin
                encode_coefficient(coefficient);
                coef_count <= coef_count + 1;
            end
        end
    end

    // coefficient driver: change at the falling edge, hold while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || coef_taken))
        begin
            if (coef_pending_q.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 20))
            begin
                in_valid <= 1'b1;
                coefficient <= coef_pending_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // symbol receiver: random stall plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (press_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 200;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet_window && ($urandom_range(0, 99) < 20);
        end
    end

    task automatic write_block_length(input logic [PosW-1:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (coef_pending_q.size() != 0 || in_valid || sym_expect_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic queue_random_coefs(input int count);
        int               left;
        int               pick;
        int               burst;
        int               nbits;
        logic [CoefW-1:0] mag;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                queue_coef('0);
                left--;
            end
            else if (pick < 56)
            begin
                burst = $urandom_range(14, 40);
                repeat (burst) queue_coef('0);
                left -= burst;
            end
            else if (pick < 98)
            begin
                nbits = $urandom_range(1, 15);
                mag = CoefW'((16'd1 << (nbits - 1)) |
                             ($urandom & ((16'd1 << (nbits - 1)) - 1)));
                queue_coef($urandom_range(0, 1) ? -mag : mag);
                left--;
            end
            else
            begin
                queue_coef(16'h8000);
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and saturation under the reset block length, then a full zero run
        queue_coef(16'h0001);
        queue_coef(16'hFFFF);
        queue_coef(16'h7FFF);
        queue_coef(16'h8001);
        queue_coef(16'h8000);
        repeat (16) queue_coef('0);
        wait_drained();

        // zero length ends the block on every coefficient, here mid-block
        write_block_length('0);
        @(posedge clk);
        queue_coef('0);
        queue_coef(16'h0003);
        wait_drained();

        foreach (phase_len[i])
        begin
            write_block_length(phase_len[i]);
            @(posedge clk);
            if (i == 3)
            begin
                press_req = 1'b1;
                queue_random_coefs(300);
            end
            else
            begin
                queue_random_coefs($urandom_range(60, 100));
            end
            wait_drained();
        end

        $display("Run covered %0d coefficients and %0d symbols (%0d end-of-block)",
                 coef_count, sym_count, blocks_done);
        $display("across %0d block-length settings, including 0, 1 and 4095", len_writes);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timeout waiting for symbols");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/acrle_pkg.sv
hdl/acrle_encoder.sv
hdl/acrle_out_buf.sv
hdl/ac_run_length_encoder.sv
sim/ac_run_length_encoder_tb.sv
